@@ sv/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

   localparam int DataWidth = 32;
   localparam int ElemW     = 32;
   localparam int FracBits  = 16;
   localparam int ProdW     = 2 * ElemW;
   localparam int AdjW      = ProdW + 1;
   localparam int DetW      = AdjW + ElemW + 1;
   localparam int MagW      = DetW - 1;
   localparam int CmW       = ProdW;
   localparam int QuotW     = 2 * FracBits;
   localparam int DivSteps  = QuotW;
   localparam int ThrW      = 63;
   localparam int CsrDataW  = 64;
   localparam int CsrAddrW  = 4;

   localparam logic CsrIdxMinDet = 1'b0;

   typedef logic [8:0][ElemW-1:0] mat_type;
   typedef logic [8:0][AdjW-1:0]  adj_array_type;
   typedef logic [8:0][CmW-1:0]   cm_array_type;
   typedef logic [8:0][QuotW-1:0] quot_array_type;

   typedef struct packed {
      logic signed [ElemW-1:0] m00;
      logic signed [ElemW-1:0] m01;
      logic signed [ElemW-1:0] m02;
      logic signed [ElemW-1:0] m10;
      logic signed [ElemW-1:0] m11;
      logic signed [ElemW-1:0] m12;
      logic signed [ElemW-1:0] m20;
      logic signed [ElemW-1:0] m21;
      logic signed [ElemW-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [ElemW-1:0] inv00;
      logic signed [ElemW-1:0] inv01;
      logic signed [ElemW-1:0] inv02;
      logic signed [ElemW-1:0] inv10;
      logic signed [ElemW-1:0] inv11;
      logic signed [ElemW-1:0] inv12;
      logic signed [ElemW-1:0] inv20;
      logic signed [ElemW-1:0] inv21;
      logic signed [ElemW-1:0] inv22;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

   // values that ride along with the quotient pipeline
   typedef struct packed {
      mat_type    x;
      logic       singular;
      logic [8:0] neg;
   } side_type;

   function automatic logic signed [ElemW-1:0] sext_in(input logic [ElemW-1:0] v);
      logic [ElemW-1:0] t;
      t = v << (ElemW - DataWidth);
      return $signed(t) >>> (ElemW - DataWidth);
   endfunction

endpackage
`default_nettype wire

@@ sv/mi3_cofactor.sv @@
`default_nettype none
module mi3_cofactor (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  mi3_pkg::req_type       in_word,
   output logic                   out_valid,
   output mi3_pkg::mat_type       out_x,
   output mi3_pkg::adj_array_type out_adj
);
   import mi3_pkg::*;

   // adj[k] = x[p]*x[q] - x[r]*x[s]
   localparam logic [3:0] CofTab [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd3, 4'd2, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd6, 4'd4},
      '{4'd6, 4'd1, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd3, 4'd1}
   };

   logic                    v0_ff, v1_ff, v2_ff;
   logic signed [ElemW-1:0] x0_in [9];
   logic signed [ElemW-1:0] x0_ff [9];
   logic signed [ElemW-1:0] x1_ff [9];
   logic signed [ElemW-1:0] x2_ff [9];
   logic signed [ProdW-1:0] prod_in [9][2];
   logic signed [ProdW-1:0] prod_ff [9][2];
   logic signed [AdjW-1:0]  adj_in [9];
   logic signed [AdjW-1:0]  adj_ff [9];

   always_comb begin
      x0_in[0] = sext_in(in_word.m00);
      x0_in[1] = sext_in(in_word.m01);
      x0_in[2] = sext_in(in_word.m02);
      x0_in[3] = sext_in(in_word.m10);
      x0_in[4] = sext_in(in_word.m11);
      x0_in[5] = sext_in(in_word.m12);
      x0_in[6] = sext_in(in_word.m20);
      x0_in[7] = sext_in(in_word.m21);
      x0_in[8] = sext_in(in_word.m22);
      for (int k = 0; k < 9; k++) begin
         prod_in[k][0] = x0_ff[CofTab[k][0]] * x0_ff[CofTab[k][1]];
         prod_in[k][1] = x0_ff[CofTab[k][2]] * x0_ff[CofTab[k][3]];
         adj_in[k] = AdjW'(prod_ff[k][0]) - AdjW'(prod_ff[k][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff   <= x0_in;
      x1_ff   <= x0_ff;
      x2_ff   <= x1_ff;
      prod_ff <= prod_in;
      adj_ff  <= adj_in;
   end

   assign out_valid = v2_ff;
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         out_x[k]   = x2_ff[k];
         out_adj[k] = adj_ff[k];
      end
   end

endmodule
`default_nettype wire

@@ sv/mi3_det.sv @@
`default_nettype none
module mi3_det (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  mi3_pkg::mat_type           in_x,
   input  mi3_pkg::adj_array_type     in_adj,
   input  logic [mi3_pkg::ThrW-1:0]   min_det,
   output logic                       out_valid,
   output mi3_pkg::side_type          out_side,
   output mi3_pkg::cm_array_type      out_cm,
   output logic [mi3_pkg::MagW-1:0]   out_dmag
);
   import mi3_pkg::*;

   localparam int PartW = AdjW - ElemW;

   logic                   v3_ff, v4_ff, v5_ff, v6_ff;
   mat_type                x3_ff, x4_ff, x5_ff, x6_ff;
   adj_array_type          adj3_ff, adj4_ff, adj5_ff;
   logic signed [AdjW-1:0] plo_in [3];
   logic signed [AdjW-1:0] phi_in [3];
   logic signed [AdjW-1:0] plo_ff [3];
   logic signed [AdjW-1:0] phi_ff [3];
   logic signed [DetW-1:0] prod_in [3];
   logic signed [DetW-1:0] prod_ff [3];
   logic signed [DetW-1:0] det_in;
   logic signed [DetW-1:0] det_ff;
   logic signed [DetW-1:0] det_abs;
   logic [MagW-1:0]        dmag_in;
   logic [MagW-1:0]        dmag_ff;
   logic                   sing_in, sing_ff;
   logic [8:0]             neg_in, neg_ff;
   cm_array_type           cm_in, cm_ff;
   logic signed [AdjW-1:0] a_s;

   // det = adj0*a + adj3*b + adj6*c, each adj split into a low 32-bit and a high 33-bit part
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         plo_in[i] = $signed({1'b0, in_adj[3*i][ElemW-1:0]}) * $signed(in_x[i]);
         phi_in[i] = $signed(in_adj[3*i][AdjW-1:ElemW]) * $signed(in_x[i]);
         prod_in[i] = (DetW'(phi_ff[i]) <<< ElemW) + DetW'(plo_ff[i]);
      end
      det_in  = prod_ff[0] + prod_ff[1] + prod_ff[2];
      det_abs = det_ff[DetW-1] ? -det_ff : det_ff;
      dmag_in = det_abs[MagW-1:0];
      sing_in = dmag_in <= MagW'(min_det);
      for (int k = 0; k < 9; k++) begin
         a_s       = $signed(adj5_ff[k]);
         neg_in[k] = a_s[AdjW-1] ^ det_ff[DetW-1];
         cm_in[k]  = a_s[AdjW-1] ? CmW'(-a_s) : CmW'(a_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      x3_ff   <= in_x;
      x4_ff   <= x3_ff;
      x5_ff   <= x4_ff;
      x6_ff   <= x5_ff;
      adj3_ff <= in_adj;
      adj4_ff <= adj3_ff;
      adj5_ff <= adj4_ff;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      prod_ff <= prod_in;
      det_ff  <= det_in;
      dmag_ff <= dmag_in;
      sing_ff <= sing_in;
      neg_ff  <= neg_in;
      cm_ff   <= cm_in;
   end

   assign out_valid         = v6_ff;
   assign out_side.x        = x6_ff;
   assign out_side.singular = sing_ff;
   assign out_side.neg      = neg_ff;
   assign out_cm            = cm_ff;
   assign out_dmag          = dmag_ff;

endmodule
`default_nettype wire

@@ sv/mi3_div.sv @@
`default_nettype none
module mi3_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  mi3_pkg::side_type        in_side,
   input  mi3_pkg::cm_array_type    in_cm,
   input  logic [mi3_pkg::MagW-1:0] in_dmag,
   output logic                     out_valid,
   output mi3_pkg::side_type        out_side,
   output logic [8:0]               out_ovf,
   output mi3_pkg::quot_array_type  out_quot
);
   import mi3_pkg::*;

   // one quotient bit per stage, nine lanes share the divisor
   logic            v_ff    [DivSteps+1];
   side_type        side_ff [DivSteps+1];
   logic [MagW-1:0] den_ff  [DivSteps+1];
   logic [MagW-1:0] rem_ff  [DivSteps+1][9];
   logic [QuotW-1:0] q_ff   [DivSteps+1][9];
   logic [8:0]      ovf_ff  [DivSteps+1];

   logic [MagW-1:0] rem0_in [9];
   logic [8:0]      ovf0_in;

   // quotient needs more than QuotW bits exactly when cm >= den
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         ovf0_in[k] = MagW'(in_cm[k]) >= in_dmag;
         rem0_in[k] = MagW'(in_cm[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      den_ff[0]  <= in_dmag;
      rem_ff[0]  <= rem0_in;
      ovf_ff[0]  <= ovf0_in;
      for (int k = 0; k < 9; k++) q_ff[0][k] <= '0;
   end

   for (genvar s = 1; s <= DivSteps; s++) begin : g_step
      logic [MagW:0]    rem2  [9];
      logic [MagW:0]    diff  [9];
      logic [MagW-1:0]  rem_in [9];
      logic [QuotW-1:0] q_in  [9];

      always_comb begin
         for (int k = 0; k < 9; k++) begin
            rem2[k]   = {rem_ff[s-1][k], 1'b0};
            diff[k]   = rem2[k] - {1'b0, den_ff[s-1]};
            rem_in[k] = diff[k][MagW] ? rem2[k][MagW-1:0] : diff[k][MagW-1:0];
            q_in[k]   = {q_ff[s-1][k][QuotW-2:0], ~diff[k][MagW]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else v_ff[s] <= v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         side_ff[s] <= side_ff[s-1];
         den_ff[s]  <= den_ff[s-1];
         ovf_ff[s]  <= ovf_ff[s-1];
         rem_ff[s]  <= rem_in;
         q_ff[s]    <= q_in;
      end
   end

   assign out_valid = v_ff[DivSteps];
   assign out_side  = side_ff[DivSteps];
   assign out_ovf   = ovf_ff[DivSteps];
   always_comb begin
      for (int k = 0; k < 9; k++) out_quot[k] = q_ff[DivSteps][k];
   end

endmodule
`default_nettype wire

@@ sv/matrix_inverse_3x3.sv @@
// channel   ports                              handshake
// request   start, busy, req_word              taken when start && !busy
// result    rsp_valid, rsp_word                one-cycle strobe, no backpressure
// config    csr_psel/penable/pwrite/paddr/...  APB, pready tied high
//
// One matrix enters every cycle; busy stays low.
// The pipeline holds the product and cofactor stages, the determinant stages,
// the restoring divider (one quotient bit per stage) and 1 output stage.
// Synchronous reset clears the valid bits and the threshold register.
`default_nettype none
module matrix_inverse_3x3 (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  mi3_pkg::req_type             req_word,
   output logic                         rsp_valid,
   output mi3_pkg::rsp_type             rsp_word,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mi3_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [mi3_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [mi3_pkg::CsrDataW-1:0] csr_prdata,
   output logic                         csr_pready
);
   import mi3_pkg::*;

   localparam int Latency = 3 + 4 + DivSteps + 1 + 1;
   localparam logic [QuotW-1:0] PosLimit = QuotW'((64'd1 << (DataWidth - 1)) - 64'd1);
   localparam logic [QuotW-1:0] NegLimit = QuotW'(64'd1 << (DataWidth - 1));

   logic            min_det_in_en;
   logic [ThrW-1:0] min_det_ff;

   logic          cof_valid;
   mat_type       cof_x;
   adj_array_type cof_adj;
   logic          det_valid;
   side_type      det_side;
   cm_array_type  det_cm;
   logic [MagW-1:0] det_dmag;
   logic          div_valid;
   side_type      div_side;
   logic [8:0]    div_ovf;
   quot_array_type div_quot;

   logic [ElemW-1:0] res [9];
   logic [QuotW-1:0] lim, mag;
   logic [8:0]       clip;
   rsp_type          rsp_in, rsp_ff;
   logic             rsp_valid_ff;

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;
   assign min_det_in_en = csr_psel && csr_penable && csr_pwrite &&
                          (csr_paddr[CsrAddrW-1] == CsrIdxMinDet);
   assign csr_prdata = (csr_paddr[CsrAddrW-1] == CsrIdxMinDet) ?
                       CsrDataW'(min_det_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) min_det_ff <= '0;
      else if (min_det_in_en) min_det_ff <= csr_pwdata[ThrW-1:0];
   end

   mi3_cofactor u_cof (
      .clock(clock), .reset(reset),
      .in_valid(start && !busy), .in_word(req_word),
      .out_valid(cof_valid), .out_x(cof_x), .out_adj(cof_adj)
   );

   mi3_det u_det (
      .clock(clock), .reset(reset),
      .in_valid(cof_valid), .in_x(cof_x), .in_adj(cof_adj), .min_det(min_det_ff),
      .out_valid(det_valid), .out_side(det_side), .out_cm(det_cm), .out_dmag(det_dmag)
   );

   mi3_div u_div (
      .clock(clock), .reset(reset),
      .in_valid(det_valid), .in_side(det_side), .in_cm(det_cm), .in_dmag(det_dmag),
      .out_valid(div_valid), .out_side(div_side), .out_ovf(div_ovf), .out_quot(div_quot)
   );

   // clip to the signed range, then apply the sign; a singular matrix passes its input through
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         lim     = div_side.neg[k] ? NegLimit : PosLimit;
         clip[k] = div_ovf[k] || (div_quot[k] > lim);
         mag     = clip[k] ? lim : div_quot[k];
         res[k]  = div_side.singular ? div_side.x[k] :
                   (div_side.neg[k] ? ElemW'(-mag) : ElemW'(mag));
      end
      rsp_in.inv00     = res[0];
      rsp_in.inv01     = res[1];
      rsp_in.inv02     = res[2];
      rsp_in.inv10     = res[3];
      rsp_in.inv11     = res[4];
      rsp_in.inv12     = res[5];
      rsp_in.inv20     = res[6];
      rsp_in.inv21     = res[7];
      rsp_in.inv22     = res[8];
      rsp_in.singular  = div_side.singular;
      rsp_in.saturated = !div_side.singular && (|clip);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= div_valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without matching request");

   a_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.singular |->
         rsp_word.inv00 == sext_in($past(req_word.m00, Latency)) &&
         rsp_word.inv22 == sext_in($past(req_word.m22, Latency)))
      else $error("singular result does not echo the input");

   a_csr: assert property (@(posedge clock) disable iff (reset)
      min_det_in_en |=> min_det_ff == $past(csr_pwdata[ThrW-1:0]))
      else $error("threshold write lost");
`endif

endmodule
`default_nettype wire

@@ tb/matrix_inverse_3x3_tb.sv @@
`default_nettype none
module matrix_inverse_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mi3_pkg::*;

   localparam int PipeDepth  = 41;
   localparam int CycleLimit = 400000;
   localparam logic [CsrAddrW-1:0] MinDetAddr = CsrAddrW'(8 * CsrIdxMinDet);
   localparam logic [31:0] One  = 32'h0001_0000;
   localparam logic [31:0] MaxE = 32'h7fff_ffff;
   localparam logic [31:0] MinE = 32'h8000_0000;

   typedef struct {
      req_type m;
      bit      has_exp;
      rsp_type exp;
   } vector_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_word = '0;
   logic                rsp_valid;
   rsp_type             rsp_word;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [CsrDataW-1:0] csr_pwdata = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   rsp_type    pending_inverses[$];
   logic [62:0] det_threshold = '0;
   int         errors = 0;
   int         cycles = 0;
   vector_type vectors[$];

   matrix_inverse_3x3 DUT (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("** matrix_inverse_3x3: FAILED **");
         $finish;
      end
   end

   function automatic rsp_type predict_inverse(req_type m, logic [62:0] thr);
      logic signed [127:0] x[9];
      logic signed [127:0] adj[9];
      logic signed [127:0] det;
      logic [127:0] dmag, cm, q, lim;
      logic [31:0] r[9];
      logic neg, sat;
      x[0] = m.m00; x[1] = m.m01; x[2] = m.m02;
      x[3] = m.m10; x[4] = m.m11; x[5] = m.m12;
      x[6] = m.m20; x[7] = m.m21; x[8] = m.m22;
      adj[0] = x[4] * x[8] - x[5] * x[7];
      adj[1] = x[2] * x[7] - x[1] * x[8];
      adj[2] = x[1] * x[5] - x[2] * x[4];
      adj[3] = x[5] * x[6] - x[3] * x[8];
      adj[4] = x[0] * x[8] - x[2] * x[6];
      adj[5] = x[3] * x[2] - x[0] * x[5];
      adj[6] = x[3] * x[7] - x[6] * x[4];
      adj[7] = x[6] * x[1] - x[0] * x[7];
      adj[8] = x[0] * x[4] - x[3] * x[1];
      det = adj[0] * x[0] + adj[3] * x[1] + adj[6] * x[2];
      dmag = det[127] ? -det : det;
      if (dmag <= {65'b0, thr}) begin
         for (int k = 0; k < 9; k++) r[k] = x[k][31:0];
         return {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b1, 1'b0};
      end
      sat = 1'b0;
      for (int k = 0; k < 9; k++) begin
         cm  = adj[k][127] ? -adj[k] : adj[k];
         neg = adj[k][127] != det[127];
         q   = (cm << 32) / dmag;
         lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         if (q > lim) begin
            q   = lim;
            sat = 1'b1;
         end
         r[k] = neg ? 32'(0 - q[31:0]) : q[31:0];
      end
      return {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b0, sat};
   endfunction

   // result check, sampled mid-cycle
   always @(negedge clock) begin
      static string names[11] = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12",
                                  "inv20", "inv21", "inv22", "singular", "saturated"};
      rsp_type want;
      logic [31:0] g, w;
      if (!reset && rsp_valid) begin
         if (pending_inverses.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            want = pending_inverses.pop_front();
            for (int i = 0; i < 11; i++) begin
               g = (i < 9) ? rsp_word[289 - 32 * i -: 32] : 32'(rsp_word[10 - i]);
               w = (i < 9) ? want[289 - 32 * i -: 32] : 32'(want[10 - i]);
               if (g !== w) begin
                  $error("%s: expected %h, got %h", names[i], w, g);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_matrix(req_type m, bit has_exp, rsp_type exp, bit idle_ok);
      bit ok;
      if (idle_ok && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= m;
      do begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
      end while (!ok);
      pending_inverses.push_back(has_exp ? exp : predict_inverse(m, det_threshold));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_inverses.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(logic [62:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MinDetAddr;
      csr_pwdata  <= {1'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      det_threshold = value;
   endtask

   function automatic logic [31:0] small_elem();
      return 32'(int'($urandom_range(0, 524288)) - 262144);
   endfunction

   function automatic req_type random_matrix();
      logic [31:0] e[9];
      int mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) begin
         case (mode)
            0, 1: e[k] = $urandom;
            6: e[k] = (k % 4 == 0) ? small_elem() + 32'(int'($urandom_range(0, 1)) * 2 - 1)
                                     * 32'h0008_0000 : small_elem() >>> 3;
            8: e[k] = 32'(int'($urandom_range(0, 32)) - 16);
            9: case ($urandom_range(0, 5))
                  0: e[k] = MinE;
                  1: e[k] = MaxE;
                  2: e[k] = '0;
                  3: e[k] = 32'd1;
                  4: e[k] = '1;
                  default: e[k] = $urandom;
               endcase
            default: e[k] = small_elem();
         endcase
      end
      // rank deficient: last row repeats the first
      if (mode == 7) begin
         e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end
      return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
   endfunction

   function automatic vector_type diag_vec(logic [31:0] d, bit has_exp, logic [31:0] inv_d,
                                           bit sing, bit sat);
      vector_type v;
      v.m = {d, 32'd0, 32'd0, 32'd0, d, 32'd0, 32'd0, 32'd0, d};
      v.has_exp = has_exp;
      v.exp = {inv_d, 32'd0, 32'd0, 32'd0, inv_d, 32'd0, 32'd0, 32'd0, inv_d, sing, sat};
      return v;
   endfunction

   function automatic vector_type fill_vec(logic [31:0] val, bit has_exp);
      vector_type v;
      v.m = {9{val}};
      v.has_exp = has_exp;
      v.exp = {{9{val}}, 1'b1, 1'b0};
      return v;
   endfunction

   task automatic random_run(int count, bit idle_ok);
      for (int i = 0; i < count; i++) send_matrix(random_matrix(), 1'b0, '0, idle_ok);
   endtask

   initial begin
      vector_type v;
      vectors.push_back(diag_vec(One, 1, One, 0, 0));
      vectors.push_back(fill_vec(32'd0, 1));
      vectors.push_back(fill_vec(MinE, 1));
      vectors.push_back(fill_vec(MaxE, 1));
      vectors.push_back(fill_vec(32'hffff_ffff, 1));
      // tiny diagonal: quotient far above range
      vectors.push_back(diag_vec(32'd1, 1, MaxE, 0, 1));
      vectors.push_back(diag_vec(32'hffff_ffff, 1, MinE, 0, 1));
      vectors.push_back(diag_vec(32'hffff_0000, 1, 32'hffff_0000, 0, 0));
      vectors.push_back(diag_vec(32'h0002_0000, 1, 32'h0000_8000, 0, 0));
      vectors.push_back(diag_vec(MinE, 0, '0, 0, 0));
      vectors.push_back(diag_vec(MaxE, 0, '0, 0, 0));
      v.has_exp = 0;
      v.m = {32'd0, One, 32'd0, 32'd0, 32'd0, One, One, 32'd0, 32'd0};
      vectors.push_back(v);
      v.m = {MinE, MaxE, 32'd1, MaxE, MinE, 32'hffff_ffff, 32'd1, 32'hffff_ffff, MinE};
      vectors.push_back(v);
      v.m = {One, 32'h0000_8000, 32'd3, 32'hfff0_0000, 32'h0003_0000, 32'd0,
             32'h0000_0100, 32'h7000_0000, 32'hffff_fffe};
      vectors.push_back(v);
      v.m = {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
             32'haaaa_aaaa, 32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f};
      vectors.push_back(v);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the threshold is zero
      foreach (vectors[i]) send_matrix(vectors[i].m, vectors[i].has_exp, vectors[i].exp, 0);
      drain_results();
      write_threshold(63'd0);
      random_run(250, 1);
      drain_results();
      write_threshold(63'h0001_0000_0000_0000);   // det of 1.0
      random_run(250, 1);
      drain_results();
      write_threshold({63{1'b1}});
      random_run(60, 1);
      drain_results();
      write_threshold(63'({$urandom, $urandom} >> $urandom_range(1, 40)));
      random_run(200, 1);
      drain_results();
      write_threshold(63'd1);
      random_run(150, 1);
      random_run(150, 0);
      drain_results();
      repeat (PipeDepth + 10) @(posedge clock);
      if (errors == 0 && pending_inverses.size() == 0) begin
         $display("** matrix_inverse_3x3: PASSED **");
      end else begin
         $display("** matrix_inverse_3x3: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/mi3_pkg.sv
sv/mi3_cofactor.sv
sv/mi3_det.sv
sv/mi3_div.sv
sv/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_tb.sv
